[src/secx_pkg.sv]
// shared types, constants and helpers of the sprite entry cell expander
package secx_pkg;

  localparam int unsigned AluW   = 16;
  localparam int unsigned PosW   = 10;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned CodeW  = 16;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned PAddrW = 3;
  localparam int unsigned PDataW = 32;

  // register index of priority_mode
  localparam logic RegPriorityMode = 1'b0;

  // priority_mode bits
  localparam int unsigned ModeColourBit3 = 0;
  localparam int unsigned ModeBothBits   = 1;

  // offset added to X to give the left column (-16)
  localparam logic [AluW-1:0] XOffset = 16'hFFF0;

  // operand set of the shared adder
  typedef struct packed {
    logic [AluW-1:0] a;
    logic [AluW-1:0] b;
    logic            cin;
  } alu_req_t;

  // 512 - 16 * height, modulo 1024, for height code 0..3
  function automatic logic [PosW-1:0] y_base(input logic [1:0] hcode);
    logic [PosW-1:0] r;
    unique case (hcode)
      2'd0:    r = 10'd496;
      2'd1:    r = 10'd480;
      2'd2:    r = 10'd448;
      default: r = 10'd384;
    endcase
    return r;
  endfunction

  // highest cell index for a height code
  function automatic logic [IdxW-1:0] last_idx(input logic [1:0] hcode);
    logic [IdxW-1:0] r;
    unique case (hcode)
      2'd0:    r = 3'd0;
      2'd1:    r = 3'd1;
      2'd2:    r = 3'd3;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

endpackage

[src/secx_alu.sv]
// shared 16-bit adder used for the X position, top row and tile code sums
module secx_alu (
  input  secx_pkg::alu_req_t            req_i,
  output logic [secx_pkg::AluW-1:0]     sum_o
);
  import secx_pkg::*;

  assign sum_o = req_i.a + req_i.b + AluW'(req_i.cin);

endmodule

[src/secx_regs.sv]
// apb register file holding priority_mode
module secx_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [secx_pkg::PAddrW-1:0]    paddr,
  input  logic [secx_pkg::PDataW-1:0]    pwdata,
  output logic [secx_pkg::PDataW-1:0]    prdata,
  output logic                           pready,
  output logic [secx_pkg::ModeW-1:0]     mode_o
);
  import secx_pkg::*;

  logic [ModeW-1:0] mode_q, mode_d;
  logic             wr_en;

  // byte address bits 1:0 are ignored
  assign wr_en = psel && penable && pwrite && (paddr[PAddrW-1] == RegPriorityMode);

  always_comb begin
    mode_d = mode_q;
    if (wr_en) begin
      mode_d = pwdata[ModeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[PAddrW-1] == RegPriorityMode) ? PDataW'(mode_q) : '0;
  assign mode_o = mode_q;

endmodule

[src/secx_seq.sv]
// sequencer: latches an entry, drives the shared adder, emits one cell per cycle while in S_EMIT
module secx_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [7:0]                     y_low_byte_i,
  input  logic [7:0]                     attr_byte_i,
  input  logic [7:0]                     code_low_byte_i,
  input  logic [7:0]                     code_high_byte_i,
  input  logic [7:0]                     x_low_byte_i,
  input  logic [7:0]                     x_attr_byte_i,
  input  logic [secx_pkg::ModeW-1:0]     mode_i,
  output secx_pkg::alu_req_t             alu_req_o,
  input  logic [secx_pkg::AluW-1:0]      alu_sum_i,
  output logic                           cell_valid_o,
  output logic [15:0]                    tile_code_o,
  output logic [3:0]                     palette_o,
  output logic                           mirror_x_o,
  output logic                           mirror_y_o,
  output logic signed [9:0]              screen_x_o,
  output logic signed [9:0]              screen_y_o,
  output logic                           over_tiles_o,
  output logic                           final_cell_o
);
  import secx_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_XPOS,
    S_YPOS,
    S_EMIT
  } state_e;

  state_e             state_q;
  logic [CodeW-1:0]   code_q;
  logic [8:0]         ypos_q;
  logic [8:0]         xpos_q;
  logic [3:0]         pal_q;
  logic               fx_q;
  logic               fy_q;
  logic [1:0]         hcode_q;
  logic               over_q;
  logic [IdxW-1:0]    idx_q;
  logic [PosW-1:0]    sx_q;
  logic [PosW-1:0]    top_q;
  logic [IdxW-1:0]    last_i;
  logic [IdxW-1:0]    off;
  logic               accept;
  logic               over_d;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);
  assign last_i = last_idx(hcode_q);
  // reversed offset is last - idx, which equals last ^ idx since idx <= last
  assign off    = fy_q ? (last_i ^ idx_q) : idx_q;

  always_comb begin
    priority if (mode_i[ModeColourBit3]) begin
      over_d = attr_byte_i[4];
    end else if (mode_i[ModeBothBits]) begin
      over_d = attr_byte_i[4] && attr_byte_i[3];
    end else begin
      over_d = 1'b0;
    end
  end

  always_comb begin
    alu_req_o = '0;
    unique case (state_q)
      S_XPOS: begin
        alu_req_o.a = AluW'(xpos_q);
        alu_req_o.b = XOffset;
      end
      S_YPOS: begin
        // base - ypos as base + ~ypos + 1
        alu_req_o.a   = ~AluW'(ypos_q);
        alu_req_o.b   = AluW'(y_base(hcode_q));
        alu_req_o.cin = 1'b1;
      end
      S_EMIT: begin
        alu_req_o.a = code_q;
        alu_req_o.b = AluW'(off);
      end
      default: begin
        alu_req_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cell_valid_o <= 1'b0;
      idx_q        <= '0;
    end else begin
      cell_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_XPOS;
            idx_q   <= '0;
          end
        end
        S_XPOS: begin
          sx_q    <= alu_sum_i[PosW-1:0];
          state_q <= S_YPOS;
        end
        S_YPOS: begin
          top_q   <= alu_sum_i[PosW-1:0];
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          cell_valid_o <= 1'b1;
          tile_code_o  <= alu_sum_i;
          palette_o    <= pal_q;
          mirror_x_o   <= fx_q;
          mirror_y_o   <= fy_q;
          screen_x_o   <= sx_q;
          screen_y_o   <= top_q + {idx_q, 4'b0000};
          over_tiles_o <= over_q;
          final_cell_o <= (idx_q == last_i);
          idx_q        <= idx_q + 1'b1;
          if (idx_q == last_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // entry fields, loaded on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      code_q  <= {code_high_byte_i, code_low_byte_i};
      ypos_q  <= {attr_byte_i[0], y_low_byte_i};
      xpos_q  <= {x_attr_byte_i[0], x_low_byte_i};
      pal_q   <= attr_byte_i[4:1];
      fx_q    <= x_attr_byte_i[1];
      fy_q    <= attr_byte_i[7];
      hcode_q <= attr_byte_i[6:5];
      over_q  <= over_d;
    end
  end

endmodule

[src/sprite_entry_cell_expander_top.sv]
// top level of the sprite entry cell expander
//
//  channel   signals                                  handshake
//  -------   ---------------------------------------  ------------------------------
//  entry     *_byte_i fields                          start_i high while busy_o low
//  cell      tile_code_o .. final_cell_o              cell_valid_o, one cycle each
//  config    psel penable pwrite paddr pwdata prdata  apb write, pready tied high
//
// an entry of 1, 2, 4 or 8 cells holds busy_o high while the shared adder works on X,
// then on the top row, then on the tile code of each cell in turn.
// cells leave on consecutive cycles, the first after states S_XPOS, S_YPOS and S_EMIT.
// a new entry is accepted in the cycle the last cell of the previous one shows,
// so no entry is taken while an earlier one is still being expanded.
// reset clears the sequencer, the strobe and priority_mode; the receiver cannot stall.
module sprite_entry_cell_expander_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [7:0]                     y_low_byte_i,
  input  logic [7:0]                     attr_byte_i,
  input  logic [7:0]                     code_low_byte_i,
  input  logic [7:0]                     code_high_byte_i,
  input  logic [7:0]                     x_low_byte_i,
  input  logic [7:0]                     x_attr_byte_i,
  output logic                           cell_valid_o,
  output logic [15:0]                    tile_code_o,
  output logic [3:0]                     palette_o,
  output logic                           mirror_x_o,
  output logic                           mirror_y_o,
  output logic signed [9:0]              screen_x_o,
  output logic signed [9:0]              screen_y_o,
  output logic                           over_tiles_o,
  output logic                           final_cell_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [secx_pkg::PAddrW-1:0]    paddr,
  input  logic [secx_pkg::PDataW-1:0]    pwdata,
  output logic [secx_pkg::PDataW-1:0]    prdata,
  output logic                           pready
);
  import secx_pkg::*;

  logic [ModeW-1:0] mode;
  alu_req_t         alu_req;
  logic [AluW-1:0]  alu_sum;

  secx_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (mode)
  );

  secx_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_sum)
  );

  secx_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .y_low_byte_i     (y_low_byte_i),
    .attr_byte_i      (attr_byte_i),
    .code_low_byte_i  (code_low_byte_i),
    .code_high_byte_i (code_high_byte_i),
    .x_low_byte_i     (x_low_byte_i),
    .x_attr_byte_i    (x_attr_byte_i),
    .mode_i           (mode),
    .alu_req_o        (alu_req),
    .alu_sum_i        (alu_sum),
    .cell_valid_o     (cell_valid_o),
    .tile_code_o      (tile_code_o),
    .palette_o        (palette_o),
    .mirror_x_o       (mirror_x_o),
    .mirror_y_o       (mirror_y_o),
    .screen_x_o       (screen_x_o),
    .screen_y_o       (screen_y_o),
    .over_tiles_o     (over_tiles_o),
    .final_cell_o     (final_cell_o)
  );

endmodule

[src/secx_chk.sv]
// port-level checker of the sprite entry cell expander and its bind
module secx_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           cell_valid_o,
  input logic [3:0]                     palette_o,
  input logic signed [9:0]              screen_x_o,
  input logic                           final_cell_o
);

  // an accepted entry occupies the block and shows no cell while it passes S_XPOS and S_YPOS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !cell_valid_o) ##1 !cell_valid_o)
    else $error("accept did not start the setup cycles");

  // cells of one entry come out back to back
  a_cells_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid_o && !final_cell_o) |=> cell_valid_o)
    else $error("gap inside a cell burst");

  // the block only drops busy once the last cell has been issued
  a_idle_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid_o && !busy_o) |-> final_cell_o)
    else $error("idle while cells remain");

  // colour and column are shared by all cells of one entry
  a_entry_fields_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid_o && $past(cell_valid_o) && !$past(final_cell_o))
      |-> ($stable(palette_o) && $stable(screen_x_o)))
    else $error("entry fields changed within a burst");

endmodule

bind sprite_entry_cell_expander_top secx_chk u_secx_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .cell_valid_o (cell_valid_o),
  .palette_o    (palette_o),
  .screen_x_o   (screen_x_o),
  .final_cell_o (final_cell_o)
);
